// ===== rtl/prbb_pkg.sv =====
// ----------------------------------------------------------------------------
// prbb_pkg
// shared constants and register codes for the projective bounding box block
// ----------------------------------------------------------------------------
`default_nettype none

package prbb_pkg;

    localparam int COEF_WIDTH     = 32;
    localparam int APB_ADDR_WIDTH = 6;
    localparam int APB_DATA_WIDTH = 64;

    // register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_AB = 3'd0,
        REG_CD = 3'd1,
        REG_EF = 3'd2,
        REG_GH = 3'd3,
        REG_I  = 3'd4
    } reg_idx_t;

    // identity matrix after reset
    localparam logic [63:0] RST_AB = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_CD = 64'h0;
    localparam logic [63:0] RST_EF = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_GH = 64'h0;
    localparam logic [31:0] RST_I  = 32'h0001_0000;

endpackage

`default_nettype wire

// ===== rtl/prbb_rect_if.sv =====
// ----------------------------------------------------------------------------
// prbb_rect_if
// request channel carrying one source rectangle
// ----------------------------------------------------------------------------
`default_nettype none

interface prbb_rect_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] src_x_low;
    logic signed [COORD_WIDTH-1:0] src_y_low;
    logic signed [COORD_WIDTH-1:0] src_x_high;
    logic signed [COORD_WIDTH-1:0] src_y_high;

    modport source (
        output valid, src_x_low, src_y_low, src_x_high, src_y_high,
        input  ready
    );
    modport sink (
        input  valid, src_x_low, src_y_low, src_x_high, src_y_high,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/prbb_box_if.sv =====
// ----------------------------------------------------------------------------
// prbb_box_if
// result channel carrying one mapped bounding box
// ----------------------------------------------------------------------------
`default_nettype none

interface prbb_box_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x_low;
    logic signed [COORD_WIDTH-1:0] out_y_low;
    logic signed [COORD_WIDTH-1:0] out_x_high;
    logic signed [COORD_WIDTH-1:0] out_y_high;
    logic                          unbounded;
    logic                          saturated;

    modport source (
        output valid, out_x_low, out_y_low, out_x_high, out_y_high, unbounded, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x_low, out_y_low, out_x_high, out_y_high, unbounded, saturated,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/projective_rect_bounding_box.sv =====
// ----------------------------------------------------------------------------
// projective_rect_bounding_box
// maps the corners of a rectangle through a 3x3 projective matrix and
// returns the bounding box of the divided corners
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  rect     | in  | valid / ready | src_x_low, src_y_low, src_x_high, src_y_high
//  box      | out | valid / ready | out_x/y_low, out_x/y_high, unbounded, saturated
//  apb      | in  | psel/penable  | paddr, pwdata, prdata (64 bit), pready
//
// one request per cycle while the pipeline is not held; the divider is a
// bit-per-stage long divider (one quotient bit per stage, eight lanes).
// reset clears the valid bits and loads the identity matrix.
// when the result register is full and not taken, the whole pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

module projective_rect_bounding_box #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    prbb_rect_if.sink                                 rect,
    prbb_box_if.source                                box,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [prbb_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [prbb_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic      [prbb_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                      pready
);

    localparam int C  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int CW = prbb_pkg::COEF_WIDTH;
    localparam int PW = C + CW;                       // product width
    localparam int SW = ((C > F) ? C : F) + CW + 2;   // row sum width
    localparam int MW = SW - 1;                       // magnitude width
    localparam int NW = MW + F;                       // numerator width
    localparam int RW = NW + C;                       // divider compare width

    localparam logic signed [C-1:0] MINV = {1'b1, {(C-1){1'b0}}};
    localparam logic signed [C-1:0] MAXV = {1'b0, {(C-1){1'b1}}};

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [63:0] coef_ab_reg, coef_cd_reg, coef_ef_reg, coef_gh_reg;
    logic [31:0] coef_i_reg;
    prbb_pkg::reg_idx_t reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = prbb_pkg::reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_ab_reg <= prbb_pkg::RST_AB;
            coef_cd_reg <= prbb_pkg::RST_CD;
            coef_ef_reg <= prbb_pkg::RST_EF;
            coef_gh_reg <= prbb_pkg::RST_GH;
            coef_i_reg  <= prbb_pkg::RST_I;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                prbb_pkg::REG_AB: coef_ab_reg <= pwdata;
                prbb_pkg::REG_CD: coef_cd_reg <= pwdata;
                prbb_pkg::REG_EF: coef_ef_reg <= pwdata;
                prbb_pkg::REG_GH: coef_gh_reg <= pwdata;
                prbb_pkg::REG_I:  coef_i_reg  <= pwdata[31:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            prbb_pkg::REG_AB: prdata = coef_ab_reg;
            prbb_pkg::REG_CD: prdata = coef_cd_reg;
            prbb_pkg::REG_EF: prdata = coef_ef_reg;
            prbb_pkg::REG_GH: prdata = coef_gh_reg;
            prbb_pkg::REG_I:  prdata = {32'd0, coef_i_reg};
            default:          prdata = '0;
        endcase
    end

    logic signed [CW-1:0] ca, cb, cc, cd, ce, cf, cg, ch, ci;
    assign ca = coef_ab_reg[63:32];
    assign cb = coef_ab_reg[31:0];
    assign cc = coef_cd_reg[63:32];
    assign cd = coef_cd_reg[31:0];
    assign ce = coef_ef_reg[63:32];
    assign cf = coef_ef_reg[31:0];
    assign cg = coef_gh_reg[63:32];
    assign ch = coef_gh_reg[31:0];
    assign ci = coef_i_reg;

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic adv;
    logic ovld_reg;

    assign adv        = !ovld_reg || box.ready;
    assign rect.ready = adv;

    // ------------------------------------------------------------------
    // stage 1: products
    // 0 a*xl 1 a*xh 2 b*yl 3 b*yh 4 d*xl 5 d*xh 6 e*yl 7 e*yh
    // 8 g*xl 9 g*xh 10 h*yl 11 h*yh
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_reg [0:11];
    logic                 v1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0]  <= PW'(ca) * PW'(rect.src_x_low);
            prod_reg[1]  <= PW'(ca) * PW'(rect.src_x_high);
            prod_reg[2]  <= PW'(cb) * PW'(rect.src_y_low);
            prod_reg[3]  <= PW'(cb) * PW'(rect.src_y_high);
            prod_reg[4]  <= PW'(cd) * PW'(rect.src_x_low);
            prod_reg[5]  <= PW'(cd) * PW'(rect.src_x_high);
            prod_reg[6]  <= PW'(ce) * PW'(rect.src_y_low);
            prod_reg[7]  <= PW'(ce) * PW'(rect.src_y_high);
            prod_reg[8]  <= PW'(cg) * PW'(rect.src_x_low);
            prod_reg[9]  <= PW'(cg) * PW'(rect.src_x_high);
            prod_reg[10] <= PW'(ch) * PW'(rect.src_y_low);
            prod_reg[11] <= PW'(ch) * PW'(rect.src_y_high);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: row sums per corner
    // corners (xl,yl) (xl,yh) (xh,yh) (xh,yl)
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sx_reg [0:3];
    logic signed [SW-1:0] sy_reg [0:3];
    logic signed [SW-1:0] sw_reg [0:3];
    logic                 v2_reg;

    for (genvar k = 0; k < 4; k++)
    begin : g_row
        localparam int XI = k >> 1;
        localparam int YI = (k >> 1) ^ (k & 1);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sx_reg[k] <= SW'(prod_reg[XI]) + SW'(prod_reg[2 + YI])
                             + (SW'(cc) <<< F);
                sy_reg[k] <= SW'(prod_reg[4 + XI]) + SW'(prod_reg[6 + YI])
                             + (SW'(cf) <<< F);
                sw_reg[k] <= SW'(prod_reg[8 + XI]) + SW'(prod_reg[10 + YI])
                             + (SW'(ci) <<< F);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: signs, magnitudes, horizon check
    // lane 2k is x of corner k, lane 2k+1 is y
    // ------------------------------------------------------------------
    logic [NW-1:0] num_reg [0:7];
    logic [MW-1:0] den_reg [0:3];
    logic          neg_reg [0:7];
    logic          unb_reg;
    logic          v3_reg;
    logic          unb_next;

    always_comb
    begin
        logic any_zero;
        logic all_pos;
        logic all_neg;
        any_zero = 1'b0;
        all_pos  = 1'b1;
        all_neg  = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            if (sw_reg[k] == '0)
                any_zero = 1'b1;
            if (sw_reg[k][SW-1])
                all_pos = 1'b0;
            else
                all_neg = 1'b0;
        end
        unb_next = any_zero || (!all_pos && !all_neg);
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_abs
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[2*k]     <= NW'(sx_reg[k][SW-1] ? MW'(-sx_reg[k]) : MW'(sx_reg[k]))
                                    << F;
                num_reg[2*k + 1] <= NW'(sy_reg[k][SW-1] ? MW'(-sy_reg[k]) : MW'(sy_reg[k]))
                                    << F;
                den_reg[k]       <= sw_reg[k][SW-1] ? MW'(-sw_reg[k]) : MW'(sw_reg[k]);
                neg_reg[2*k]     <= sx_reg[k][SW-1] ^ sw_reg[k][SW-1];
                neg_reg[2*k + 1] <= sy_reg[k][SW-1] ^ sw_reg[k][SW-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            unb_reg <= unb_next;
    end

    // ------------------------------------------------------------------
    // divider: stage 0 holds the overflow check, stage s+1 resolves
    // quotient bit C-1-s
    // ------------------------------------------------------------------
    logic [NW-1:0] drem_reg  [0:C][0:7];
    logic [C-1:0]  dq_reg    [0:C][0:7];
    logic [MW-1:0] dden_reg  [0:C][0:3];
    logic          dneg_reg  [0:C][0:7];
    logic          dovf_reg  [0:C][0:7];
    logic          dunb_reg  [0:C];
    logic          dv_reg    [0:C];

    logic [NW-1:0] drem_next [0:C][0:7];
    logic [C-1:0]  dq_next   [0:C][0:7];
    logic          dovf_next [0:7];

    always_comb
    begin
        logic [RW-1:0] sub;
        for (int l = 0; l < 8; l++)
        begin
            drem_next[0][l] = num_reg[l];
            dq_next[0][l]   = '0;
            dovf_next[l]    = RW'(num_reg[l]) >= (RW'(den_reg[l >> 1]) << C);
        end
        for (int s = 0; s < C; s++)
        begin
            for (int l = 0; l < 8; l++)
            begin
                sub = RW'(dden_reg[s][l >> 1]) << (C - 1 - s);
                if (RW'(drem_reg[s][l]) >= sub)
                begin
                    drem_next[s+1][l] = NW'(RW'(drem_reg[s][l]) - sub);
                    dq_next[s+1][l]   = dq_reg[s][l] | (C'(1) << (C - 1 - s));
                end
                else
                begin
                    drem_next[s+1][l] = drem_reg[s][l];
                    dq_next[s+1][l]   = dq_reg[s][l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 8; l++)
            begin
                dneg_reg[0][l] <= neg_reg[l];
                dovf_reg[0][l] <= dovf_next[l];
            end
            for (int k = 0; k < 4; k++)
                dden_reg[0][k] <= den_reg[k];
            dunb_reg[0] <= unb_reg;
            for (int s = 0; s <= C; s++)
            begin
                for (int l = 0; l < 8; l++)
                begin
                    drem_reg[s][l] <= drem_next[s][l];
                    dq_reg[s][l]   <= dq_next[s][l];
                end
            end
            for (int s = 0; s < C; s++)
            begin
                for (int l = 0; l < 8; l++)
                begin
                    dneg_reg[s+1][l] <= dneg_reg[s][l];
                    dovf_reg[s+1][l] <= dovf_reg[s][l];
                end
                for (int k = 0; k < 4; k++)
                    dden_reg[s+1][k] <= dden_reg[s][k];
                dunb_reg[s+1] <= dunb_reg[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // sign, clamp
    // ------------------------------------------------------------------
    logic signed [C-1:0] fin_val_reg [0:7];
    logic                fin_sat_reg;
    logic                fin_unb_reg;
    logic                v5_reg;
    logic signed [C-1:0] fin_val_next [0:7];
    logic                fin_sat_next;

    always_comb
    begin
        logic [C-1:0] q;
        logic         lane_sat;
        fin_sat_next = 1'b0;
        for (int l = 0; l < 8; l++)
        begin
            q = dq_reg[C][l];
            if (dneg_reg[C][l])
                lane_sat = dovf_reg[C][l] || (q[C-1] && (q[C-2:0] != '0));
            else
                lane_sat = dovf_reg[C][l] || q[C-1];
            if (lane_sat)
                fin_val_next[l] = dneg_reg[C][l] ? MINV : MAXV;
            else
                fin_val_next[l] = dneg_reg[C][l] ? $signed(~q + C'(1)) : $signed(q);
            fin_sat_next = fin_sat_next | lane_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 8; l++)
                fin_val_reg[l] <= fin_val_next[l];
            fin_sat_reg <= fin_sat_next;
            fin_unb_reg <= dunb_reg[C];
        end
    end

    // ------------------------------------------------------------------
    // min / max and result register
    // ------------------------------------------------------------------
    function automatic logic signed [C-1:0] smin(input logic signed [C-1:0] p,
                                                  input logic signed [C-1:0] q);
        return (q < p) ? q : p;
    endfunction

    function automatic logic signed [C-1:0] smax(input logic signed [C-1:0] p,
                                                  input logic signed [C-1:0] q);
        return (p < q) ? q : p;
    endfunction

    logic signed [C-1:0] ox_lo_reg, oy_lo_reg, ox_hi_reg, oy_hi_reg;
    logic                ounb_reg, osat_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (fin_unb_reg)
            begin
                ox_lo_reg <= MINV;
                oy_lo_reg <= MINV;
                ox_hi_reg <= MAXV;
                oy_hi_reg <= MAXV;
                osat_reg  <= 1'b0;
            end
            else
            begin
                ox_lo_reg <= smin(smin(fin_val_reg[0], fin_val_reg[2]),
                                  smin(fin_val_reg[4], fin_val_reg[6]));
                oy_lo_reg <= smin(smin(fin_val_reg[1], fin_val_reg[3]),
                                  smin(fin_val_reg[5], fin_val_reg[7]));
                ox_hi_reg <= smax(smax(fin_val_reg[0], fin_val_reg[2]),
                                  smax(fin_val_reg[4], fin_val_reg[6]));
                oy_hi_reg <= smax(smax(fin_val_reg[1], fin_val_reg[3]),
                                  smax(fin_val_reg[5], fin_val_reg[7]));
                osat_reg  <= fin_sat_reg;
            end
            ounb_reg <= fin_unb_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            for (int s = 0; s <= C; s++)
                dv_reg[s] <= 1'b0;
            v5_reg   <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= rect.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
            for (int s = 0; s < C; s++)
                dv_reg[s+1] <= dv_reg[s];
            v5_reg    <= dv_reg[C];
            ovld_reg  <= v5_reg;
        end
    end

    assign box.valid      = ovld_reg;
    assign box.out_x_low  = ox_lo_reg;
    assign box.out_y_low  = oy_lo_reg;
    assign box.out_x_high = ox_hi_reg;
    assign box.out_y_high = oy_hi_reg;
    assign box.unbounded  = ounb_reg;
    assign box.saturated  = osat_reg;

endmodule

`default_nettype wire

// ===== sim/projective_rect_bounding_box_tb.sv =====
// ----------------------------------------------------------------------------
// projective_rect_bounding_box_tb
// drives rectangles through the projective bounding box block under several
// matrix settings written over apb, predicts every box with exact wide
// arithmetic and checks each result in order, with random stalls on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module projective_rect_bounding_box_tb;

    typedef struct packed {
        logic signed [31:0] xl;
        logic signed [31:0] yl;
        logic signed [31:0] xh;
        logic signed [31:0] yh;
    } rect_t;

    typedef struct packed {
        logic signed [31:0] xl;
        logic signed [31:0] yl;
        logic signed [31:0] xh;
        logic signed [31:0] yh;
        logic               unb;
        logic               sat;
    } box_t;

    typedef enum int {MAT_IDENT, MAT_AFFINE, MAT_PERSP, MAT_WILD, MAT_ZERO} mat_kind_t;

    localparam logic signed [31:0] MAX_C = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN_C = 32'sh8000_0000;
    localparam int LATENCY   = 38;
    localparam int WDOG_MAX  = 20000;
    localparam int LONG_HOLD = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [prbb_pkg::APB_ADDR_WIDTH-1:0] paddr = '0;
    logic [prbb_pkg::APB_DATA_WIDTH-1:0] pwdata = '0;
    logic [prbb_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic pready;

    prbb_rect_if #(.COORD_WIDTH(32)) rect_ch ();
    prbb_box_if  #(.COORD_WIDTH(32)) box_ch ();

    projective_rect_bounding_box u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rect    (rect_ch),
        .box     (box_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // matrix as the block should hold it
    logic [63:0] m_ab = prbb_pkg::RST_AB, m_cd = prbb_pkg::RST_CD;
    logic [63:0] m_ef = prbb_pkg::RST_EF, m_gh = prbb_pkg::RST_GH;
    logic [31:0] m_i = prbb_pkg::RST_I;

    rect_t pending_rects[$];
    box_t  expected_boxes[$];
    int    mismatches = 0;
    bit    quiet = 1'b0;
    bit    hold_req = 1'b0;

    function automatic logic signed [31:0] clip_div(input logic signed [127:0] num,
                                                    input logic signed [127:0] den,
                                                    inout logic sat);
        logic signed [127:0] q;
        q = (num <<< 16) / den;
        if (q > 128'sd2147483647)
        begin
            sat = 1'b1;
            return MAX_C;
        end
        if (q < -128'sd2147483648)
        begin
            sat = 1'b1;
            return MIN_C;
        end
        return q[31:0];
    endfunction

    function automatic box_t project_box(rect_t r);
        logic signed [127:0] ca, cb, cc, cd, ce, cf, cg, ch, ci;
        logic signed [127:0] px[4], py[4], wx[4], wy[4], ww[4];
        logic signed [31:0]  qx, qy;
        logic any_pos, any_neg, any_zero, sat;
        box_t b;
        ca = $signed(m_ab[63:32]); cb = $signed(m_ab[31:0]);
        cc = $signed(m_cd[63:32]); cd = $signed(m_cd[31:0]);
        ce = $signed(m_ef[63:32]); cf = $signed(m_ef[31:0]);
        cg = $signed(m_gh[63:32]); ch = $signed(m_gh[31:0]);
        ci = $signed(m_i);
        px[0] = r.xl; py[0] = r.yl;
        px[1] = r.xl; py[1] = r.yh;
        px[2] = r.xh; py[2] = r.yh;
        px[3] = r.xh; py[3] = r.yl;
        any_pos = 1'b0; any_neg = 1'b0; any_zero = 1'b0; sat = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            wx[k] = ca * px[k] + cb * py[k] + (cc <<< 16);
            wy[k] = cd * px[k] + ce * py[k] + (cf <<< 16);
            ww[k] = cg * px[k] + ch * py[k] + (ci <<< 16);
            if (ww[k] == 0) any_zero = 1'b1;
            else if (ww[k] < 0) any_neg = 1'b1;
            else any_pos = 1'b1;
        end
        b.unb = any_zero || (any_pos && any_neg);
        if (b.unb)
        begin
            b.xl = MIN_C; b.yl = MIN_C; b.xh = MAX_C; b.yh = MAX_C; b.sat = 1'b0;
            return b;
        end
        for (int k = 0; k < 4; k++)
        begin
            qx = clip_div(wx[k], ww[k], sat);
            qy = clip_div(wy[k], ww[k], sat);
            if (k == 0 || qx < b.xl) b.xl = qx;
            if (k == 0 || qx > b.xh) b.xh = qx;
            if (k == 0 || qy < b.yl) b.yl = qy;
            if (k == 0 || qy > b.yh) b.yh = qy;
        end
        b.sat = sat;
        return b;
    endfunction

    // rectangle sender
    int src_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        if (!rst_n)
        begin
            rect_ch.valid <= 1'b0;
            rect_ch.src_x_low <= '0;
            rect_ch.src_y_low <= '0;
            rect_ch.src_x_high <= '0;
            rect_ch.src_y_high <= '0;
        end
        else
        begin
            if (rect_ch.valid && rect_ch.ready)
            begin
                expected_boxes.push_back(project_box(pending_rects[0]));
                void'(pending_rects.pop_front());
            end
            if (rect_ch.valid && !rect_ch.ready)
                nv = 1'b1;
            else if (src_gap > 0)
            begin
                src_gap--;
                nv = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                src_gap = $urandom_range(1, 19) - 1;
                nv = 1'b0;
            end
            else
                nv = pending_rects.size() > 0;
            rect_ch.valid <= nv;
            if (nv)
            begin
                rect_ch.src_x_low  <= pending_rects[0].xl;
                rect_ch.src_y_low  <= pending_rects[0].yl;
                rect_ch.src_x_high <= pending_rects[0].xh;
                rect_ch.src_y_high <= pending_rects[0].yh;
            end
        end
    end

    // box receiver, with one long hold-off on request
    int  sink_gap = 0;
    bit  hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_ch.ready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            sink_gap = LONG_HOLD;
            box_ch.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            box_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            sink_gap = $urandom_range(1, 19) - 1;
            box_ch.ready <= 1'b0;
        end
        else
            box_ch.ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        box_t got, want;
        if (rst_n && box_ch.valid && box_ch.ready)
        begin
            got = '{box_ch.out_x_low, box_ch.out_y_low, box_ch.out_x_high,
                    box_ch.out_y_high, box_ch.unbounded, box_ch.saturated};
            if (expected_boxes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected box %h", got);
            end
            else
            begin
                want = expected_boxes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"box mismatch: expected x %0d..%0d y %0d..%0d ",
                                  "unb %b sat %b, got x %0d..%0d y %0d..%0d unb %b sat %b"},
                                 want.xl, want.xh, want.yl, want.yh, want.unb, want.sat,
                                 got.xl, got.xh, got.yl, got.yh, got.unb, got.sat);
                end
            end
        end
    end

    // watchdog on lack of progress
    int stuck = 0;
    always @(posedge clk)
    begin
        if ((rect_ch.valid && rect_ch.ready) || (box_ch.valid && box_ch.ready)
            || (pending_rects.size() == 0 && expected_boxes.size() == 0))
            stuck = 0;
        else
            stuck++;
        if (stuck >= WDOG_MAX)
        begin
            $display("[projective_rect_bounding_box] ERROR");
            $finish;
        end
    end

    // write one register, then read it back
    task automatic apb_write(prbb_pkg::reg_idx_t idx, logic [63:0] v);
        logic [63:0] want;
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            prbb_pkg::REG_AB: m_ab = v;
            prbb_pkg::REG_CD: m_cd = v;
            prbb_pkg::REG_EF: m_ef = v;
            prbb_pkg::REG_GH: m_gh = v;
            default: m_i = v[31:0];
        endcase
        want = (idx == prbb_pkg::REG_I) ? {32'h0, v[31:0]} : v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!pready || prdata !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register readback mismatch: expected %h, got %h", want, prdata);
        end
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coef(mat_kind_t kind, int role);
        // role 0 linear, 1 offset, 2 perspective, 3 w offset
        case (kind)
            MAT_IDENT: return (role == 0) ? 32'h0001_0000 : 32'h0;
            MAT_ZERO:  return 32'h0;
            MAT_WILD:
                case ($urandom_range(0, 3))
                    0: return MAX_C;
                    1: return MIN_C;
                    2: return 32'h0;
                    default: return $urandom;
                endcase
            default:
            begin
                if (role == 1) return $urandom;
                if (role == 2)
                    return (kind == MAT_AFFINE) ? 32'h0 : $urandom_range(0, 1023) - 512;
                if (role == 3) return $urandom_range(0, 1) ? $urandom_range(1, 32'h40000)
                                                           : -$urandom_range(1, 32'h40000);
                return $urandom_range(0, 3) == 0 ? $urandom
                                                 : $urandom_range(0, 32'h80000) - 32'h40000;
            end
        endcase
    endfunction

    task automatic set_matrix(mat_kind_t kind);
        logic [31:0] a, b, c, d, e, f, g, h, i;
        a = pick_coef(kind, 0); b = pick_coef(kind, 0);
        c = pick_coef(kind, 1); d = pick_coef(kind, 0);
        e = pick_coef(kind, 0); f = pick_coef(kind, 1);
        g = pick_coef(kind, 2); h = pick_coef(kind, 2);
        i = pick_coef(kind, 3);
        if (kind == MAT_IDENT)
        begin
            b = 32'h0; d = 32'h0; i = 32'h0001_0000;
        end
        apb_write(prbb_pkg::REG_AB, {a, b});
        apb_write(prbb_pkg::REG_CD, {c, d});
        apb_write(prbb_pkg::REG_EF, {e, f});
        apb_write(prbb_pkg::REG_GH, {g, h});
        apb_write(prbb_pkg::REG_I, {32'h0, i});
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? MAX_C : MIN_C;
            1, 2: return $urandom;
            default: return $urandom_range(0, 32'h200000) - 32'h100000;
        endcase
    endfunction

    task automatic queue_rect(logic [31:0] xl, logic [31:0] yl, logic [31:0] xh,
                              logic [31:0] yh);
        pending_rects.push_back('{xl, yl, xh, yh});
    endtask

    task automatic queue_random(int n);
        for (int k = 0; k < n; k++)
            queue_rect(pick_coord(), pick_coord(), pick_coord(), pick_coord());
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_rects.size() > 0 || expected_boxes.size() > 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity after reset: extremes, swapped edges, zero box
        queue_rect(32'h0, 32'h0, 32'h0, 32'h0);
        queue_rect(MIN_C, MIN_C, MAX_C, MAX_C);
        queue_rect(MAX_C, MAX_C, MIN_C, MIN_C);
        queue_rect(32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0003_0000);
        queue_rect(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001);
        drain();

        // w zero everywhere: unbounded
        set_matrix(MAT_ZERO);
        queue_rect(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
        queue_rect(MIN_C, MAX_C, MAX_C, MIN_C);
        drain();

        // extreme coefficients: saturation and sign flips
        set_matrix(MAT_WILD);
        apb_write(prbb_pkg::REG_I, {32'h0, MAX_C});
        queue_rect(MIN_C, MIN_C, MAX_C, MAX_C);
        queue_rect(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000);
        queue_rect(32'h0, 32'h0, 32'h0, 32'h0);
        drain();

        // w equal to x: rectangles crossing zero, touching it, or on one side
        apb_write(prbb_pkg::REG_AB, 64'h0001_0000_0000_0000);
        apb_write(prbb_pkg::REG_CD, 64'h0);
        apb_write(prbb_pkg::REG_EF, 64'h0001_0000_0000_0000);
        apb_write(prbb_pkg::REG_GH, 64'h0001_0000_0000_0000);
        apb_write(prbb_pkg::REG_I, 64'h0);
        queue_rect(32'hfffe_0000, 32'h0, 32'h0002_0000, 32'h0001_0000);
        queue_rect(32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0001_0000);
        queue_rect(32'hfffe_0000, 32'h0, 32'hffff_0000, 32'h0001_0000);
        queue_rect(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
        drain();

        // random phases; the receiver holds off once while requests keep coming
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: set_matrix(MAT_AFFINE);
                1: set_matrix(MAT_PERSP);
                2: set_matrix(p == 2 ? MAT_WILD : MAT_AFFINE);
                default: set_matrix(MAT_PERSP);
            endcase
            if (p == 1)
                hold_req = 1'b1;
            if (p == 7)
                quiet = 1'b1;
            queue_random(100);
            drain();
        end

        if (mismatches == 0)
            $display("[projective_rect_bounding_box] OK");
        else
            $display("[projective_rect_bounding_box] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== projective_rect_bounding_box.f =====
rtl/prbb_pkg.sv
rtl/prbb_rect_if.sv
rtl/prbb_box_if.sv
rtl/projective_rect_bounding_box.sv
sim/projective_rect_bounding_box_tb.sv
